@@ rtl/core/btr_pkg.sv @@
// Shared types and constants for the bitmap text renderer.
// No dependencies; imported by every module of the block.
`default_nettype none

package btr_pkg;

  // Store geometry
  localparam int GLYPH_COUNT = 256;
  localparam int MAX_GLYPH_W = 16;
  localparam int MAX_GLYPH_H = 32;
  localparam int POS_BITS    = 13;
  localparam int CODE_BITS   = $clog2(GLYPH_COUNT);
  localparam int ROW_BITS    = $clog2(MAX_GLYPH_H);
  localparam int ADDR_BITS   = CODE_BITS + ROW_BITS;
  localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_H;

  // Field widths
  localparam int CW_BITS    = 5;
  localparam int CH_BITS    = 6;
  localparam int FRAME_BITS = 12;
  localparam int COLOR_BITS = 32;
  localparam int CMD_BITS   = 2;
  localparam int IN_BITS    = 88;
  localparam int OUT_BITS   = 80;
  localparam int CFG_IDX_BITS = 2;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CHAR  = 2'd2;

  // Special character codes
  localparam logic [CODE_BITS-1:0] CODE_NUL     = 8'd0;
  localparam logic [CODE_BITS-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_BITS-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [2:0]           TAB_CELLS    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHAR_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd3;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // take the input item this cycle
    logic issue;   // read the next glyph row
  } btr_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_draw;    // input item is a printable character
    logic can_issue;  // read stage is free to take a row
    logic row_last;   // current row is the final glyph row
  } btr_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/bitmap_text_renderer.sv @@
// Bitmap text renderer: glyph store, cursor and clipped row writes.
// Non-drawing items (load, start, newline, tab, code 0) are taken while idle; a
// drawn character makes one glyph-store read per clamped glyph row, taking no new
// item until its last row is read; rows pass the read stage and output register.
// Synchronous reset clears the cursor, margin and tab phase, sets the color to
// all ones and the registers to 8/16/640/480; the glyph store is not cleared.
`default_nettype none

module bitmap_text_renderer
  import btr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // input items
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // glyph_code[7:0], glyph_row[12:8], row_bits[28:13], pos_x[41:29],
  // pos_y[54:42], color[86:55], zero pad [87]
  input  wire logic [IN_BITS-1:0]      s_tdata,
  // command[1:0]
  input  wire logic [CMD_BITS-1:0]     s_tuser,
  // result items
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // row_y[12:0], col_x[25:13], write_mask[41:26], pixel_color[73:42],
  // zero pad [79:74]
  output logic [OUT_BITS-1:0]          m_tdata,
  // last
  output logic                         m_tlast,
  // configuration writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [FRAME_BITS-1:0]   cfg_data
);

  btr_cmd_t  cmd;
  btr_stat_t stat;

  logic [POS_BITS-1:0]    out_row_y;
  logic [POS_BITS-1:0]    out_col_x;
  logic [MAX_GLYPH_W-1:0] out_mask;
  logic [COLOR_BITS-1:0]  out_color;

  // register writes are taken whenever out of reset
  assign cfg_ready = !rst;

  btr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_cmd      (s_tuser),
    .in_code     (s_tdata[7:0]),
    .in_row      (s_tdata[12:8]),
    .in_row_bits (s_tdata[28:13]),
    .in_pos_x    (s_tdata[41:29]),
    .in_pos_y    (s_tdata[54:42]),
    .in_color    (s_tdata[86:55]),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_row_y   (out_row_y),
    .out_col_x   (out_col_x),
    .out_mask    (out_mask),
    .out_color   (out_color),
    .out_last    (m_tlast)
  );

  assign m_tdata = {6'b0, out_color, out_mask, out_col_x, out_row_y};

endmodule

`default_nettype wire

@@ rtl/core/btr_ctrl.sv @@
// Controller for the bitmap text renderer: takes items and sequences glyph rows.
// Depends on btr_pkg.
`default_nettype none

module btr_ctrl
  import btr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire btr_stat_t stat,
  output btr_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_t;

  state_t state, state_next;

  // Outputs and next state; no item is taken while in reset
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
        if (cmd.accept && stat.is_draw) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW: begin
        cmd.issue = stat.can_issue;
        if (stat.can_issue && stat.row_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/btr_datapath.sv @@
// Datapath for the bitmap text renderer: registers, cursor, glyph store,
// row pipeline and output register. Depends on btr_pkg.
`default_nettype none

module btr_datapath
  import btr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [FRAME_BITS-1:0]    cfg_data,
  // input item fields
  input  wire logic [CMD_BITS-1:0]      in_cmd,
  input  wire logic [CODE_BITS-1:0]     in_code,
  input  wire logic [ROW_BITS-1:0]      in_row,
  input  wire logic [MAX_GLYPH_W-1:0]   in_row_bits,
  input  wire logic [POS_BITS-1:0]      in_pos_x,
  input  wire logic [POS_BITS-1:0]      in_pos_y,
  input  wire logic [COLOR_BITS-1:0]    in_color,
  // control
  input  wire btr_cmd_t                 cmd,
  output btr_stat_t                     stat,
  // result item
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [POS_BITS-1:0]           out_row_y,
  output logic [POS_BITS-1:0]           out_col_x,
  output logic [MAX_GLYPH_W-1:0]        out_mask,
  output logic [COLOR_BITS-1:0]         out_color,
  output logic                          out_last
);

  // Configuration registers
  logic [CW_BITS-1:0]    char_width;
  logic [CH_BITS-1:0]    char_height;
  logic [FRAME_BITS-1:0] frame_width;
  logic [FRAME_BITS-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_width   <= CW_BITS'(8);
      char_height  <= CH_BITS'(16);
      frame_width  <= FRAME_BITS'(640);
      frame_height <= FRAME_BITS'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHAR_WIDTH:   char_width   <= cfg_data[CW_BITS-1:0];
        REG_CHAR_HEIGHT:  char_height  <= cfg_data[CH_BITS-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped cell size
  logic [CW_BITS-1:0] cell_w;
  logic [CH_BITS-1:0] cell_h;

  always_comb begin
    cell_w = char_width;
    if (char_width == '0) begin
      cell_w = CW_BITS'(1);
    end else if (char_width > CW_BITS'(MAX_GLYPH_W)) begin
      cell_w = CW_BITS'(MAX_GLYPH_W);
    end
    cell_h = char_height;
    if (char_height == '0) begin
      cell_h = CH_BITS'(1);
    end else if (char_height > CH_BITS'(MAX_GLYPH_H)) begin
      cell_h = CH_BITS'(MAX_GLYPH_H);
    end
  end

  // Input decode
  logic is_load, is_start, is_char, is_newline, is_tab;

  assign is_load    = (in_cmd == CMD_LOAD);
  assign is_start   = (in_cmd == CMD_START);
  assign is_char    = (in_cmd == CMD_CHAR);
  assign is_newline = is_char && (in_code == CODE_NEWLINE);
  assign is_tab     = is_char && (in_code == CODE_TAB);
  assign stat.is_draw = is_char && (in_code != CODE_NUL) && !is_newline && !is_tab;

  // Cursor state
  logic [POS_BITS-1:0]   cursor_x, cursor_y, left_margin;
  logic [1:0]            tab_phase;
  logic [COLOR_BITS-1:0] draw_color;
  logic [CODE_BITS-1:0]  cur_code;
  logic [ROW_BITS-1:0]   row_cnt;
  logic [7:0]            tab_step;
  logic                  char_done;

  assign tab_step  = (8'(TAB_CELLS) - 8'({1'b0, tab_phase})) * 8'(cell_w);
  assign char_done = cmd.issue && stat.row_last;
  assign stat.row_last = ({1'b0, row_cnt} == (cell_h - CH_BITS'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      left_margin <= '0;
      tab_phase   <= '0;
      draw_color  <= '1;
    end else if (cmd.accept && is_start) begin
      cursor_x    <= in_pos_x;
      cursor_y    <= in_pos_y;
      left_margin <= in_pos_x;
      draw_color  <= in_color;
      tab_phase   <= '0;
    end else if (cmd.accept && is_newline) begin
      cursor_x  <= left_margin;
      cursor_y  <= cursor_y + POS_BITS'(cell_h);
      tab_phase <= '0;
    end else if (cmd.accept && is_tab) begin
      cursor_x  <= cursor_x + POS_BITS'(tab_step);
      tab_phase <= '0;
    end else if (char_done) begin
      cursor_x  <= cursor_x + POS_BITS'(cell_w);
      tab_phase <= tab_phase + 2'd1;
    end
  end

  // Character code and row counter for drawing
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_code <= in_code;
      row_cnt  <= '0;
    end else if (cmd.issue) begin
      row_cnt  <= row_cnt + ROW_BITS'(1);
    end
  end

  // Column visibility, recomputed every cycle from the stable cursor
  logic [MAX_GLYPH_W-1:0] col_mask;
  logic [MAX_GLYPH_W-1:0] col_mask_next;
  logic [POS_BITS-1:0]    col_pos [MAX_GLYPH_W];

  always_comb begin
    for (int i = 0; i < MAX_GLYPH_W; i++) begin
      col_pos[i] = cursor_x + POS_BITS'(i);
      col_mask_next[i] = !col_pos[i][POS_BITS-1]
                         && (col_pos[i][FRAME_BITS-1:0] < frame_width)
                         && (CW_BITS'(i) < cell_w);
    end
  end

  always_ff @(posedge clk) begin
    col_mask <= col_mask_next;
  end

  // Glyph store
  logic [MAX_GLYPH_W-1:0] glyph_store [STORE_DEPTH];
  logic [MAX_GLYPH_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.accept && is_load) begin
      glyph_store[{in_code, in_row}] <= in_row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data <= glyph_store[{cur_code, row_cnt}];
    end
  end

  // Read stage: row data arrives with its position and color
  logic                   p_valid;
  logic [POS_BITS-1:0]    p_row_y;
  logic [POS_BITS-1:0]    p_col_x;
  logic                   p_row_vis;
  logic [MAX_GLYPH_W-1:0] p_col_mask;
  logic [COLOR_BITS-1:0]  p_color;
  logic                   p_last;
  logic [POS_BITS-1:0]    row_y;
  logic                   load_out;

  assign row_y          = cursor_y + POS_BITS'(row_cnt);
  assign load_out       = p_valid && (!out_valid || out_ready);
  assign stat.can_issue = !p_valid || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (cmd.issue) begin
      p_valid <= 1'b1;
    end else if (load_out) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p_row_y    <= row_y;
      p_col_x    <= cursor_x;
      p_row_vis  <= !row_y[POS_BITS-1] && (row_y[FRAME_BITS-1:0] < frame_height);
      p_col_mask <= col_mask;
      p_color    <= draw_color;
      p_last     <= stat.row_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row_y <= p_row_y;
      out_col_x <= p_col_x;
      out_mask  <= p_row_vis ? (rd_data & p_col_mask) : '0;
      out_color <= p_color;
      out_last  <= p_last;
    end
  end

endmodule

`default_nettype wire

@@ tb/bitmap_text_renderer_test.sv @@
// Self-checking testbench for bitmap_text_renderer: stream stimulus, config writes,
// a scoreboard that predicts every clipped glyph row write.
// Depends on btr_pkg and the bitmap_text_renderer RTL only.
`timescale 1ns / 1ps

module bitmap_text_renderer_test
  import btr_pkg::*;
();

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT = 600000;
  localparam int SETTLE = 40;
  localparam int NPRE = 2;

  // One expected row write
  typedef struct packed {
    bit [12:0] row_y;
    bit [12:0] col_x;
    bit [15:0] mask;
    bit [31:0] color;
    bit        last;
  } row_write_t;

  // Text raster predictor: glyph store, cursor, registers, expected writes
  class text_raster_board;
    bit [15:0]  glyphs [256][32];
    bit         loaded [256][32];
    bit [12:0]  cur_x, cur_y, margin;
    bit [1:0]   tab_phase;
    bit [31:0]  color;
    bit [4:0]   reg_cw;
    bit [5:0]   reg_ch;
    bit [11:0]  reg_fw, reg_fh;
    row_write_t expected_rows[$];
    int         mismatches;

    function new();
      cur_x = '0;
      cur_y = '0;
      margin = '0;
      tab_phase = '0;
      color = '1;
      reg_cw = 5'd8;
      reg_ch = 6'd16;
      reg_fw = 12'd640;
      reg_fh = 12'd480;
      mismatches = 0;
    endfunction

    // cell size as used, clamped to the glyph limits
    function int cell_w();
      if (reg_cw < 1) return 1;
      if (reg_cw > MAX_GLYPH_W) return MAX_GLYPH_W;
      return reg_cw;
    endfunction

    function int cell_h();
      if (reg_ch < 1) return 1;
      if (reg_ch > MAX_GLYPH_H) return MAX_GLYPH_H;
      return reg_ch;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [FRAME_BITS-1:0] val);
      case (idx)
        REG_CHAR_WIDTH:   reg_cw = val[4:0];
        REG_CHAR_HEIGHT:  reg_ch = val[5:0];
        REG_FRAME_WIDTH:  reg_fw = val;
        REG_FRAME_HEIGHT: reg_fh = val;
        default: ;
      endcase
    endfunction

    // true when drawing this code reads only loaded rows
    function bit glyph_ready(logic [7:0] code);
      int r;
      if (code == CODE_NUL || code == CODE_TAB || code == CODE_NEWLINE) return 1;
      for (r = 0; r < cell_h(); r++)
        if (!loaded[code][r]) return 0;
      return 1;
    endfunction

    // accepted input item: update state, queue the rows it draws
    function void take_item(logic [CMD_BITS-1:0] cmd, logic [IN_BITS-1:0] d);
      bit [7:0]   code;
      bit [12:0]  col, ry;
      bit [15:0]  colmask, bits;
      int         w, h, i, r, sc, sy, adv;
      row_write_t rw;
      code = d[7:0];
      w = cell_w();
      h = cell_h();
      case (cmd)
        CMD_LOAD: begin
          glyphs[code][d[12:8]] = d[28:13];
          loaded[code][d[12:8]] = 1'b1;
        end
        CMD_START: begin
          cur_x = d[41:29];
          cur_y = d[54:42];
          margin = d[41:29];
          color = d[86:55];
          tab_phase = '0;
        end
        CMD_CHAR: begin
          if (code == CODE_NEWLINE) begin
            cur_x = margin;
            cur_y = cur_y + h[12:0];
            tab_phase = '0;
          end else if (code == CODE_TAB) begin
            adv = (TAB_CELLS - tab_phase) * w;
            cur_x = cur_x + adv[12:0];
            tab_phase = '0;
          end else if (code != CODE_NUL) begin
            // columns inside the frame
            colmask = '0;
            for (i = 0; i < w; i++) begin
              col = cur_x + i[12:0];
              sc = int'($signed(col));
              if (sc >= 0 && sc < int'(reg_fw)) colmask[i] = 1'b1;
            end
            for (r = 0; r < h; r++) begin
              ry = cur_y + r[12:0];
              sy = int'($signed(ry));
              bits = glyphs[code][r];
              if (!(sy >= 0 && sy < int'(reg_fh))) bits = '0;
              rw.row_y = ry;
              rw.col_x = cur_x;
              rw.mask = bits & colmask;
              rw.color = color;
              rw.last = (r == h - 1);
              expected_rows.push_back(rw);
            end
            cur_x = cur_x + w[12:0];
            tab_phase = tab_phase + 2'd1;
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row write mismatch on %s: expected %h, got %h", name, exp, act);
      end
    endfunction

    // accepted result item: check against the oldest expected row
    function void match_row(logic [OUT_BITS-1:0] td, logic tl);
      row_write_t rw;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row write: data %h last %b", td, tl);
        return;
      end
      rw = expected_rows.pop_front();
      compare("row_y", 32'(rw.row_y), 32'(td[12:0]));
      compare("col_x", 32'(rw.col_x), 32'(td[25:13]));
      compare("write_mask", 32'(rw.mask), 32'(td[41:26]));
      compare("pixel_color", rw.color, td[73:42]);
      compare("last", 32'(rw.last), 32'(tl));
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_BITS-1:0]      s_tdata;
  logic [CMD_BITS-1:0]     s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [OUT_BITS-1:0]     m_tdata;
  logic                    m_tlast;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [FRAME_BITS-1:0]   cfg_data;

  text_raster_board board;
  int               cycles;
  int               burst_left;
  logic [7:0]       preload_codes [NPRE];

  typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_e;
  rx_mode_e rx_mode;
  int       rx_mode_left;
  int       rx_stall_left;

  bitmap_text_renderer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock, low first so the first rising edge comes after setup
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("bitmap_text_renderer_test: errors");
      $finish;
    end
  end

  // Result side: check accepted rows, stall in changing patterns
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.match_row(m_tdata, m_tlast);
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_STEADY:   m_tready <= 1'b1;
      RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
      RX_PERIODIC: m_tready <= (cycles % 3 != 0);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  function automatic logic [IN_BITS-1:0] pack_in(logic [7:0] code, logic [4:0] row,
                                                logic [15:0] bits, logic [12:0] px,
                                                logic [12:0] py, logic [31:0] col);
    return {1'b0, col, py, px, bits, row, code};
  endfunction

  // position biased toward frame edges and the wrap point
  function automatic logic [12:0] pick_pos(int extent, int cell_px);
    int v;
    case ($urandom_range(0, 9))
      0, 1:    v = $urandom;
      2:       v = 4095 - $urandom_range(0, 3 * cell_px);
      3:       v = -4096 + $urandom_range(0, cell_px);
      4, 5:    v = extent - $urandom_range(0, 2 * cell_px);
      6:       v = -$urandom_range(0, 2 * cell_px);
      default: v = $urandom_range(0, extent + cell_px);
    endcase
    return v[12:0];
  endfunction

  // code that is a control code or a printable code whose rows are all loaded
  function automatic logic [7:0] pick_code();
    logic [7:0] c;
    c = 8'($urandom);
    if (!board.glyph_ready(c)) c = preload_codes[$urandom_range(0, NPRE - 1)];
    return c;
  endfunction

  // one input item, sent in bursts with random gaps
  task automatic send_item(input logic [CMD_BITS-1:0] cmd, input logic [IN_BITS-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.take_item(cmd, data);
  endtask

  task automatic send_char(input logic [7:0] code);
    send_item(CMD_CHAR, pack_in(code, 5'($urandom), 16'($urandom), 13'($urandom),
                                13'($urandom), $urandom));
  endtask

  task automatic send_start(input logic [12:0] px, input logic [12:0] py,
                            input logic [31:0] col);
    send_item(CMD_START, pack_in(8'($urandom), 5'($urandom), 16'($urandom), px, py, col));
  endtask

  task automatic load_glyph(input logic [7:0] code, input int rows);
    int r;
    for (r = 0; r < rows; r++)
      send_item(CMD_LOAD, pack_in(code, 5'(r), 16'($urandom), 13'($urandom),
                                  13'($urandom), $urandom));
  endtask

  // wait until every expected row is out and the block has settled
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [FRAME_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic set_cell(input int cw, input int ch, input int fw, input int fh);
    drain();
    write_cfg(REG_CHAR_WIDTH, FRAME_BITS'(cw));
    write_cfg(REG_CHAR_HEIGHT, FRAME_BITS'(ch));
    write_cfg(REG_FRAME_WIDTH, FRAME_BITS'(fw));
    write_cfg(REG_FRAME_HEIGHT, FRAME_BITS'(fh));
    cfg_valid <= 1'b0;
  endtask

  // mostly text runs with random content, some loads, restarts and noise
  task automatic random_phase(input int count);
    int n, pick;
    send_start(pick_pos(int'(board.reg_fw), board.cell_w()),
               pick_pos(int'(board.reg_fh), board.cell_h()), $urandom);
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)      send_char(pick_code());
      else if (pick < 66) send_char(CODE_NEWLINE);
      else if (pick < 74) send_char(CODE_TAB);
      else if (pick < 77) send_char(CODE_NUL);
      else if (pick < 83)
        send_item(CMD_LOAD, pack_in(8'($urandom), 5'($urandom), 16'($urandom),
                                    13'($urandom), 13'($urandom), $urandom));
      else if (pick < 86) load_glyph(8'($urandom), board.cell_h());
      else if (pick < 94)
        send_start(pick_pos(int'(board.reg_fw), board.cell_w()),
                   pick_pos(int'(board.reg_fh), board.cell_h()), $urandom);
      else
        send_item(CMD_UNUSED, pack_in(8'($urandom), 5'($urandom), 16'($urandom),
                                      13'($urandom), 13'($urandom), $urandom));
    end
  endtask

  initial begin
    int k;
    board = new();
    preload_codes = '{8'h55, 8'hAA};
    cycles <= 0;
    burst_left = 0;
    rx_mode = RX_STEADY;
    rx_mode_left = 0;
    rx_stall_left = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_LOAD;
    m_tready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_CHAR_WIDTH;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // fill glyphs whose codes hold every code bit both set and clear; row extremes
    for (k = 0; k < NPRE; k++) load_glyph(preload_codes[k], MAX_GLYPH_H);
    send_item(CMD_LOAD, pack_in(8'hAA, 5'd0, 16'hFFFF, '0, '0, '0));
    send_item(CMD_LOAD, pack_in(8'h55, 5'd31, 16'h0000, '0, '0, '0));

    // directed text at reset settings
    send_start(13'd0, 13'd0, 32'h0000_0000);
    send_char(8'h55);
    send_char(8'hAA);
    send_char(CODE_TAB);
    send_char(8'h55);
    send_char(CODE_NEWLINE);
    send_char(CODE_NUL);
    send_item(CMD_UNUSED, pack_in(8'd65, '1, '1, '1, '1, '1));
    // clipped at right and bottom edges
    send_start(13'd636, 13'd470, 32'hFFFF_FFFF);
    send_char(8'h55);
    // clipped at left and top edges
    send_start(-13'sd4, -13'sd8, $urandom);
    send_char(8'hAA);
    // cursor wraps from the top of the position range
    send_start(13'd4095, 13'd4095, $urandom);
    send_char(8'h55);
    send_char(8'hAA);
    send_start(13'h1000, 13'h1000, $urandom);
    send_char(8'h55);
    send_char(CODE_NEWLINE);
    send_char(CODE_TAB);
    send_char(CODE_TAB);
    send_char(8'hAA);
    // loading a control code changes nothing it does
    send_item(CMD_LOAD, pack_in(CODE_NEWLINE, 5'd0, 16'hFFFF, '0, '0, '0));
    send_char(CODE_NEWLINE);
    send_char(8'h55);

    // random phases over several settings, extremes included
    set_cell(16, 32, 4095, 4095);
    random_phase(8);
    set_cell(1, 1, 1, 1);
    random_phase(8);
    set_cell(0, 0, 0, 0);
    random_phase(6);
    set_cell(31, 63, $urandom_range(1, 4095), $urandom_range(1, 4095));
    random_phase(8);
    set_cell(8, 16, 64, 48);
    random_phase(8);
    set_cell($urandom_range(1, 16), $urandom_range(1, 32), $urandom_range(1, 4095),
             $urandom_range(1, 4095));
    random_phase(8);

    drain();
    if (board.mismatches == 0 && board.expected_rows.size() == 0) begin
      $display("bitmap_text_renderer_test: clean");
    end else begin
      $display("bitmap_text_renderer_test: errors");
    end
    $finish;
  end

endmodule
